/* sv/bitmap_store_find_next_set_core_defines.svh */
// Assertion macros used by the bitmap store RTL.
`ifndef BITMAP_STORE_FIND_NEXT_SET_CORE_DEFINES_SVH
`define BITMAP_STORE_FIND_NEXT_SET_CORE_DEFINES_SVH

// Checked on every rising edge of i_clk once reset is released.
`define BMFNS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset cycles included.
`define BMFNS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* sv/bmfns_pkg.sv */
package bmfns_pkg;

    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = 64;
    localparam int CAPACITY  = WORD_BITS * NUM_WORDS;

    localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OFF_W  = $clog2(WORD_BITS);
    localparam int IDX_W  = 11;
    localparam int CNT_W  = 12;
    localparam int REQ_W  = 3;
    localparam int CMP_W  = (ADDR_W + OFF_W + 1 > CNT_W) ? ADDR_W + OFF_W + 1 : CNT_W;

    localparam logic [CNT_W-1:0] BIT_COUNT_RST = CNT_W'(2048);

    localparam logic [REQ_W-1:0] REQ_SET     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TEST    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLR_ALL = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SET_ALL = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] bit_index;
    } t_in_word;

    typedef struct packed {
        logic             bit_value;
        logic [CNT_W-1:0] found_index;
        logic             index_error;
    } t_out_word;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } t_mem_req;

    // Register value clipped to the number of bits the store can hold.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cfg);
        logic [CMP_W:0] cap;
        cap = (CMP_W + 1)'(CAPACITY);
        if ((CMP_W + 1)'(cfg) > cap) begin
            return CNT_W'(CAPACITY);
        end
        return cfg;
    endfunction

    // Bits of word addr that lie below count.
    function automatic logic [WORD_BITS-1:0] word_limit(input logic [ADDR_W-1:0] addr,
                                                        input logic [CNT_W-1:0] count);
        logic [CMP_W-1:0] base;
        logic [CMP_W-1:0] cnt;
        logic [CMP_W-1:0] diff;
        base = CMP_W'(addr) << OFF_W;
        cnt  = CMP_W'(count);
        diff = cnt - base;
        if (cnt >= base + CMP_W'(WORD_BITS)) begin
            return '1;
        end else if (cnt <= base) begin
            return '0;
        end
        return ~({WORD_BITS{1'b1}} << diff[OFF_W-1:0]);
    endfunction

    // Position of the lowest set bit; the word must be nonzero.
    function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_BITS-1:0] d);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (d[i]) begin
                pos = OFF_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* sv/bmfns_store.sv */
module bmfns_store
    import bmfns_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mem_req             i_req,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // A word that was never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* sv/bitmap_store_find_next_set_core.sv */
// Bitmap store of up to 2048 bits held as 64 words of 32 bits in one synchronous
// memory, with set, clear, test, find-next-set, clear-all and set-all requests.
// Only the first bit_count bits are in use (a count above 2048 acts as 2048). Every
// request word gives exactly one result word. Set and clear are a read-modify-write
// of one memory word and test is a read of one; a request with an index out of
// range, or an unused code, finishes in the idle state without touching memory.
// Find reads one word after another, from the word holding the start bit up to
// the word holding the hit or the last word in use. Clear-all and set-all sweep
// every word through the single write port. Only one request is in work at a
// time. A finished result sits in an output register, so the next request is
// taken while that result still waits downstream. The store reads as all zeros
// after reset, with no clearing pass. The bit_count register is written through
// its own port, which is always ready, and should only change while the block is
// idle.
`include "bitmap_store_find_next_set_core_defines.svh"

module bitmap_store_find_next_set_core
    import bmfns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RMW  = 3'd1;
    localparam logic [2:0] ST_FIND = 3'd2;
    localparam logic [2:0] ST_FILL = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        r_state,     n_state;
    logic [REQ_W-1:0]  r_req,       n_req;
    logic [IDX_W-1:0]  r_idx,       n_idx;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [ADDR_W-1:0] r_addr,      n_addr;
    logic              r_first,     n_first;
    t_out_word         r_res,       n_res;
    logic              r_out_vld,   n_out_vld;
    t_out_word         r_out_word,  n_out_word;
    logic [CNT_W-1:0]  r_bit_count;

    t_mem_req             w_mem_req;
    logic [WORD_BITS-1:0] w_rd_data;
    logic                 w_fin;
    t_out_word            w_res;
    logic                 w_out_free;
    logic [CNT_W-1:0]     w_eff;
    logic [ADDR_W-1:0]    w_in_addr;
    logic                 w_in_range;
    logic [WORD_BITS-1:0] w_bit_mask;
    logic [WORD_BITS-1:0] w_find_word;
    logic [CMP_W-1:0]     w_next_base;

    bmfns_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // The output register can take a new result when empty or being drained.
    assign w_out_free = !r_out_vld || !i_out_stall;

    assign w_eff      = eff_count(r_bit_count);
    assign w_in_addr  = ADDR_W'(i_in_word.bit_index >> OFF_W);
    assign w_in_range = CNT_W'(i_in_word.bit_index) < w_eff;
    assign w_bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_idx[OFF_W-1:0];

    // In the first word of a find the bits below the start position are ignored,
    // and in every word the bits at or above the count.
    assign w_find_word = w_rd_data & word_limit(r_addr, r_count) &
                         (r_first ? ({WORD_BITS{1'b1}} << r_idx[OFF_W-1:0])
                                  : {WORD_BITS{1'b1}});
    assign w_next_base = (CMP_W'(r_addr) << OFF_W) + CMP_W'(WORD_BITS);

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_idx     = r_idx;
        n_count   = r_count;
        n_addr    = r_addr;
        n_first   = r_first;
        n_res     = r_res;
        w_mem_req = '0;
        w_fin     = 1'b0;
        w_res     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_word.req_type;
                    n_idx   = i_in_word.bit_index;
                    n_count = w_eff;
                    n_addr  = w_in_addr;
                    case (i_in_word.req_type)
                        REQ_SET, REQ_CLEAR, REQ_TEST: begin
                            if (w_in_range) begin
                                w_mem_req.rd_en   = 1'b1;
                                w_mem_req.rd_addr = w_in_addr;
                                n_state           = ST_RMW;
                            end else begin
                                w_fin             = 1'b1;
                                w_res.index_error = 1'b1;
                            end
                        end
                        REQ_FIND: begin
                            if (w_in_range) begin
                                w_mem_req.rd_en   = 1'b1;
                                w_mem_req.rd_addr = w_in_addr;
                                n_first           = 1'b1;
                                n_state           = ST_FIND;
                            end else begin
                                w_fin             = 1'b1;
                                w_res.found_index = w_eff;
                            end
                        end
                        REQ_CLR_ALL, REQ_SET_ALL: begin
                            n_addr  = '0;
                            n_state = ST_FILL;
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                w_fin             = 1'b1;
                w_mem_req.wr_addr = r_addr;
                case (r_req)
                    REQ_SET: begin
                        w_mem_req.wr_en   = 1'b1;
                        w_mem_req.wr_data = w_rd_data | w_bit_mask;
                    end
                    REQ_CLEAR: begin
                        w_mem_req.wr_en   = 1'b1;
                        w_mem_req.wr_data = w_rd_data & ~w_bit_mask;
                    end
                    default: begin
                        w_res.bit_value = |(w_rd_data & w_bit_mask);
                    end
                endcase
            end
            ST_FIND: begin
                n_first = 1'b0;
                if (|w_find_word) begin
                    w_fin             = 1'b1;
                    w_res.found_index = CNT_W'({r_addr, lowest_set(w_find_word)});
                end else if (w_next_base >= CMP_W'(r_count) ||
                             r_addr == ADDR_W'(NUM_WORDS - 1)) begin
                    w_fin             = 1'b1;
                    w_res.found_index = r_count;
                end else begin
                    w_mem_req.rd_en   = 1'b1;
                    w_mem_req.rd_addr = r_addr + 1'b1;
                    n_addr            = r_addr + 1'b1;
                end
            end
            ST_FILL: begin
                w_mem_req.wr_en   = 1'b1;
                w_mem_req.wr_addr = r_addr;
                w_mem_req.wr_data = (r_req == REQ_SET_ALL) ? word_limit(r_addr, r_count)
                                                           : '0;
                if (r_addr == ADDR_W'(NUM_WORDS - 1)) begin
                    w_fin = 1'b1;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is free,
        // and otherwise waits in r_res.
        if (w_fin) begin
            if (w_out_free) begin
                n_state = ST_IDLE;
            end else begin
                n_res   = w_res;
                n_state = ST_DONE;
            end
        end
    end

    always_comb begin
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_word = r_out_word;
        if (w_fin && w_out_free) begin
            n_out_vld  = 1'b1;
            n_out_word = w_res;
        end else if (r_state == ST_DONE && w_out_free) begin
            n_out_vld  = 1'b1;
            n_out_word = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_vld   <= 1'b0;
            r_bit_count <= BIT_COUNT_RST;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bit_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_count    <= n_count;
        r_addr     <= n_addr;
        r_first    <= n_first;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    `BMFNS_ASSERT(a_no_write_idle, (r_state == ST_IDLE) |-> !w_mem_req.wr_en, "memory written while idle")
    `BMFNS_ASSERT(a_find_reads, (r_state == ST_FIND) && !w_fin |-> w_mem_req.rd_en, "find walk stalled without a read")
    `BMFNS_ASSERT(a_done_blocked, (r_state == ST_DONE) |-> r_out_vld, "result held back while output register empty")
    `BMFNS_ASSERT(a_err_clean, o_out_valid && o_out_word.index_error |-> !o_out_word.bit_value && (o_out_word.found_index == '0), "error result carries data")
    `BMFNS_ASSERT_ALWAYS(a_found_cap, o_out_valid |-> o_out_word.found_index <= CNT_W'(CAPACITY), "found index beyond capacity")

endmodule

/* bench/bitmap_store_checker.sv */
module bitmap_store_checker
    import bmfns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_word         i_in_word,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_word        i_out_word,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the bitmap and of the bit_count register.
    logic [WORD_BITS-1:0] shadow_words [NUM_WORDS];
    logic [CNT_W-1:0]     shadow_count;
    t_out_word            awaited_results [$];
    int                   fail_count = 0;
    int                   checked_count = 0;
    int                   pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;

    function automatic int bits_in_use();
        return (shadow_count > CNT_W'(CAPACITY)) ? CAPACITY : int'(shadow_count);
    endfunction

    function automatic logic [CNT_W-1:0] next_set_from(int start, int limit);
        for (int i = start; i < limit; i++) begin
            if (shadow_words[i / WORD_BITS][i % WORD_BITS]) begin
                return CNT_W'(i);
            end
        end
        return CNT_W'(limit);
    endfunction

    // Applies one request word to the shadow bitmap and returns its result word.
    function automatic t_out_word apply_request(t_in_word w);
        t_out_word r;
        int        limit;
        int        idx;
        r     = '0;
        limit = bits_in_use();
        idx   = int'(w.bit_index);
        case (w.req_type)
            REQ_SET, REQ_CLEAR, REQ_TEST: begin
                if (idx >= limit) begin
                    r.index_error = 1'b1;
                end else if (w.req_type == REQ_SET) begin
                    shadow_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
                end else if (w.req_type == REQ_CLEAR) begin
                    shadow_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                end else begin
                    r.bit_value = shadow_words[idx / WORD_BITS][idx % WORD_BITS];
                end
            end
            REQ_FIND: begin
                r.found_index = next_set_from(idx, limit);
            end
            REQ_CLR_ALL: begin
                for (int k = 0; k < NUM_WORDS; k++) begin
                    shadow_words[k] = '0;
                end
            end
            REQ_SET_ALL: begin
                for (int k = 0; k < NUM_WORDS; k++) begin
                    for (int b = 0; b < WORD_BITS; b++) begin
                        shadow_words[k][b] = (k * WORD_BITS + b < limit);
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_result(t_out_word got);
        t_out_word want;
        if (awaited_results.size() == 0) begin
            $error("unexpected result word %h with nothing outstanding", got);
            fail_count++;
            return;
        end
        want = awaited_results.pop_front();
        checked_count++;
        if (got.bit_value !== want.bit_value) begin
            $error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
            fail_count++;
        end
        if (got.found_index !== want.found_index) begin
            $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
            fail_count++;
        end
        if (got.index_error !== want.index_error) begin
            $error("index_error: expected %0d, got %0d", want.index_error, got.index_error);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                shadow_words[k] = '0;
            end
            shadow_count = BIT_COUNT_RST;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                shadow_count = i_cfg_data;
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                compare_result(i_out_word);
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                awaited_results.push_back(apply_request(i_in_word));
            end
        end
        pending_count = awaited_results.size();
    end

endmodule

/* bench/tb_top.sv */
module tb_top
    import bmfns_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Request codes the block leaves unused; they must still give a result word.
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    // The slowest requests are a find over every word and a full sweep; this many quiet
    // cycles leaves them room to finish, so the block has gone idle.
    localparam int SETTLE_CYCLES = 80;
    localparam int NUM_SEGMENTS  = 9;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_word         i_in_word;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_word        o_out_word;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    int fail_count;
    int pending_count;
    int checked_count;

    // Percent of cycles in which the sender holds back, and the receiver stalls.
    int send_idle_pct = 8;
    int recv_idle_pct = 46;
    int words_sent    = 0;
    int counts_used   = 0;

    bitmap_store_find_next_set_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    bitmap_store_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending_count),
        .o_checked   (checked_count)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // The receiver stalls at random, decided fresh at every falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Sends one request word. It is called at a falling edge and returns at the falling
    // edge after the word was taken, with valid still high, so that back-to-back words
    // keep valid up without a dip. Random idle cycles go in front of the word.
    task automatic send_req(input logic [REQ_W-1:0] req, input int idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = '{req_type: req, bit_index: IDX_W'(idx)};
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Stops sending, waits for every outstanding result word, then lets the block settle.
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // The count register may only change while the block is idle, so drain first.
    task automatic write_count(input logic [CNT_W-1:0] value);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do begin
            @(posedge i_clk);
        end while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        counts_used++;
    endtask

    // Register values for the random segments. They include zero, one, the full
    // capacity, one past it and the largest value the field can hold.
    function automatic logic [CNT_W-1:0] segment_count(input int seg);
        case (seg)
            0:       return 12'd4095;
            1:       return 12'd1;
            2:       return 12'd2048;
            3:       return 12'd0;
            4:       return 12'd37;
            5:       return 12'd2047;
            6:       return 12'd64;
            7:       return 12'd1500;
            default: return 12'd2049;
        endcase
    endfunction

    // Mostly bit operations and finds, with the occasional sweep and unused code.
    function automatic logic [REQ_W-1:0] random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) begin
            return REQ_SET;
        end else if (r < 42) begin
            return REQ_CLEAR;
        end else if (r < 66) begin
            return REQ_TEST;
        end else if (r < 90) begin
            return REQ_FIND;
        end else if (r < 93) begin
            return REQ_CLR_ALL;
        end else if (r < 97) begin
            return REQ_SET_ALL;
        end
        return ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
    endfunction

    // Most indices land inside the bits in use; some sit on the boundary and some
    // anywhere in the field, so out-of-range requests keep turning up.
    function automatic int random_index(input int in_use);
        int r;
        r = $urandom_range(0, 99);
        if (in_use == 0 || r < 15) begin
            return $urandom_range(0, 2047);
        end else if (r < 25) begin
            case ($urandom_range(0, 2))
                0:       return 0;
                1:       return in_use - 1;
                default: return (in_use > 2047) ? 2047 : in_use;
            endcase
        end
        return $urandom_range(0, in_use - 1);
    endfunction

    initial begin
        int in_use;
        int seg_len;
        logic [CNT_W-1:0] count_value;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_out_stall = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words at the reset count of 2048: both ends of the index range,
        // a word boundary, finds that hit, skip words and run off the end, both
        // unused codes, and both sweeps.
        send_req(REQ_SET, 0);
        send_req(REQ_SET, 2047);
        send_req(REQ_SET, 31);
        send_req(REQ_SET, 32);
        send_req(REQ_TEST, 0);
        send_req(REQ_TEST, 2047);
        send_req(REQ_TEST, 1);
        send_req(REQ_FIND, 0);
        send_req(REQ_FIND, 1);
        send_req(REQ_FIND, 33);
        send_req(REQ_FIND, 2047);
        send_req(REQ_CLEAR, 2047);
        send_req(REQ_FIND, 33);
        send_req(REQ_SPARE_LO, 2047);
        send_req(REQ_SPARE_HI, 0);
        send_req(REQ_TEST, 2047);
        send_req(REQ_CLR_ALL, 0);
        send_req(REQ_FIND, 0);
        send_req(REQ_SET_ALL, 2047);
        send_req(REQ_TEST, 1000);

        // Lower the count while every bit is still set. Bits left above the new
        // count must stay invisible to find, and indices at the count are errors.
        write_count(12'd40);
        send_req(REQ_FIND, 45);
        send_req(REQ_SET, 40);
        send_req(REQ_TEST, 40);
        send_req(REQ_CLEAR, 39);
        send_req(REQ_FIND, 39);
        send_req(REQ_SET_ALL, 0);

        // Random segments, each under its own count. The first three favor receiver
        // stalls, the next three sender gaps, and the last three run at full rate.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            count_value = segment_count(seg);
            write_count(count_value);
            if (seg < 3) begin
                send_idle_pct = 8;
                recv_idle_pct = 46;
            end else if (seg < 6) begin
                send_idle_pct = 46;
                recv_idle_pct = 8;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            in_use  = (count_value > CNT_W'(CAPACITY)) ? CAPACITY : int'(count_value);
            // A zero count leaves no bit in use: bit requests are errors and finds come back empty, so keep it short.
            seg_len = (in_use == 0) ? 30 : 112;
            repeat (seg_len) send_req(random_request(), random_index(in_use));
        end

        drain();
        $display("Sent %0d request words under %0d bit_count settings;", words_sent,
                 counts_used);
        $display("compared %0d result words with %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
